/* design/tpf_pkg.sv */
package tpf_pkg;

  localparam int ADDR_W     = 16;
  localparam int LEVEL_W    = 5;
  localparam int ROW_W      = 16;
  localparam int PIXEL_W    = 2;
  localparam int ROW_PIXELS = 8;
  localparam int PUSH_LIMIT = 8;
  localparam int MAX_LEVEL  = 16;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_START = 2'd0;
  localparam opcode_t OP_TICK  = 2'd1;
  localparam opcode_t OP_POP   = 2'd2;

  // tile data lives at 0x8000, so the top nibble of a plane address is fixed
  localparam logic [3:0] TILE_BASE_NIB = 4'h8;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_TILE,
    STEP_LOW,
    STEP_HIGH,
    STEP_PUSH
  } fetch_step_t;

  typedef struct packed {
    logic             clear;
    logic             pop;
    logic             push;
    logic [ROW_W-1:0] row;
  } tpf_q_ctl_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               pixel_valid;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] level_nxt;
  } tpf_q_stat_t;

endpackage

/* design/tpf_queue.sv */
module tpf_queue
  import tpf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tpf_q_ctl_t  ctl,
  output tpf_q_stat_t stat
);

  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam logic [HW-1:0] LAST_SLOT = HW'(QUEUE_DEPTH - 1);
  localparam logic [HW:0]   DEPTH_X   = (HW + 1)'(QUEUE_DEPTH);

  logic [PIXEL_W-1:0] pixel_queue_r [QUEUE_DEPTH];
  logic [HW-1:0]      head_r, head_nxt;
  logic [LEVEL_W-1:0] count_r, count_nxt;
  logic [HW-1:0]      slot [ROW_PIXELS];
  logic               pop_ok;

  assign pop_ok = ctl.pop && (count_r != '0);

  // slot of each pushed pixel, wrapped once (sum stays below twice the depth)
  always_comb begin
    logic [HW:0] sum;
    for (int i = 0; i < ROW_PIXELS; i++) begin
      sum = (HW + 1)'(head_r) + (HW + 1)'(count_r) + (HW + 1)'(i);
      if (sum >= DEPTH_X) begin
        sum = sum - DEPTH_X;
      end
      slot[i] = sum[HW-1:0];
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (ctl.push) begin
      count_nxt = count_r + LEVEL_W'(ROW_PIXELS);
    end else if (pop_ok) begin
      head_nxt  = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // leftmost pixel first: plane bit 7 goes in first
  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear) begin
      for (int i = 0; i < ROW_PIXELS; i++) begin
        pixel_queue_r[slot[i]] <= {ctl.row[ROW_W-1-i], ctl.row[ROW_PIXELS-1-i]};
      end
    end
  end

  assign stat.pixel       = pop_ok ? pixel_queue_r[head_r] : '0;
  assign stat.pixel_valid = pop_ok;
  assign stat.level       = count_r;
  assign stat.level_nxt   = count_nxt;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LEVEL_W'(MAX_LEVEL))
    else $error("queue level above bound");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> count_r <= LEVEL_W'(PUSH_LIMIT))
    else $error("push without room");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> count_r == '0 && head_r == '0)
    else $error("clear left queue non-empty");
`endif

endmodule

/* design/tpf_fetch.sv */
module tpf_fetch
  import tpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  opcode_t            opcode,
  input  logic [ADDR_W-1:0]  map_row_address,
  input  logic [2:0]         tile_line,
  input  logic [7:0]         read_data,
  input  logic [LEVEL_W-1:0] queue_level,
  output logic               push,
  output logic [ROW_W-1:0]   row,
  output logic [ADDR_W-1:0]  read_address_nxt
);

  fetch_step_t       step_r, step_nxt;
  logic              phase_r, phase_nxt;
  logic [7:0]        tile_cnt_r, tile_cnt_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [2:0]        line_r, line_nxt;
  logic [7:0]        tile_num_r, tile_num_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              start, advance, push_go;

  assign start   = en && (opcode == OP_START);
  assign advance = en && (opcode == OP_TICK) && phase_r;
  assign push_go = advance && (step_r == STEP_PUSH)
                   && (queue_level <= LEVEL_W'(PUSH_LIMIT));

  // next state
  always_comb begin
    step_nxt     = step_r;
    phase_nxt    = phase_r;
    tile_cnt_nxt = tile_cnt_r;
    base_nxt     = base_r;
    line_nxt     = line_r;
    tile_num_nxt = tile_num_r;
    row_nxt      = row_r;
    if (start) begin
      step_nxt     = STEP_TILE;
      phase_nxt    = 1'b0;
      tile_cnt_nxt = '0;
      base_nxt     = map_row_address;
      line_nxt     = tile_line;
    end else if (en && (opcode == OP_TICK)) begin
      phase_nxt = !phase_r;
      if (phase_r) begin
        unique case (step_r)
          STEP_TILE: begin
            tile_num_nxt = read_data;
            step_nxt     = STEP_LOW;
          end
          STEP_LOW: begin
            row_nxt  = {row_r[15:8], read_data};
            step_nxt = STEP_HIGH;
          end
          STEP_HIGH: begin
            row_nxt  = {read_data, row_r[7:0]};
            step_nxt = STEP_PUSH;
          end
          STEP_PUSH: begin
            if (push_go) begin
              tile_cnt_nxt = tile_cnt_r + 1'b1;
              step_nxt     = STEP_TILE;
            end
          end
          STEP_IDLE: begin
            step_nxt = STEP_IDLE;
          end
          default: begin
            step_nxt = STEP_IDLE;
          end
        endcase
      end
    end
  end

  // outputs: address the next reading step uses, after this item
  always_comb begin
    push = push_go;
    row  = row_r;
    unique case (step_nxt)
      STEP_TILE, STEP_PUSH: read_address_nxt = base_nxt + ADDR_W'(tile_cnt_nxt);
      STEP_LOW:  read_address_nxt = {TILE_BASE_NIB, tile_num_nxt, line_nxt, 1'b0};
      STEP_HIGH: read_address_nxt = {TILE_BASE_NIB, tile_num_nxt, line_nxt, 1'b1};
      default:   read_address_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= STEP_IDLE;
      phase_r    <= 1'b0;
      tile_cnt_r <= '0;
      base_r     <= '0;
      line_r     <= '0;
      tile_num_r <= '0;
      row_r      <= '0;
    end else begin
      step_r     <= step_nxt;
      phase_r    <= phase_nxt;
      tile_cnt_r <= tile_cnt_nxt;
      base_r     <= base_nxt;
      line_r     <= line_nxt;
      tile_num_r <= tile_num_nxt;
      row_r      <= row_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stay_active: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != STEP_IDLE |=> step_r != STEP_IDLE)
    else $error("fetch fell back to idle");

  a_push_step: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> step_r == STEP_TILE && !phase_r)
    else $error("push did not restart tile read");
`endif

endmodule

/* design/tile_pixel_fetcher_top.sv */
// Background tile pixel fetcher with a pixel queue. One item is taken per clock
// while out_ready holds; each result passes the input register, then the result
// register; in_ready drops only while the result register is held by out_ready.
// Opcode 0 starts a line at in_map_row_address / in_tile_line and empties the
// queue; opcode 1 is a dot tick, every second one advancing the fetch (tile
// number, low plane, high plane, push of eight pixels once the queue holds 8 or
// fewer); opcode 2 pops one pixel. Memory is outside: out_read_address is the
// address the next reading tick needs, and that tick brings the byte on
// in_read_data. The queue is held in flip-flops of QUEUE_DEPTH entries.
module tile_pixel_fetcher_top
  import tpf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [15:0]        in_map_row_address,
  input  logic [2:0]         in_tile_line,
  input  logic [7:0]         in_read_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_pixel,
  output logic               out_pixel_valid,
  output logic               out_queue_not_empty,
  output logic [15:0]        out_read_address,
  output logic [4:0]         out_queue_level
);

  logic               s1_valid_r;
  opcode_t            s1_opcode_r;
  logic [ADDR_W-1:0]  s1_map_r;
  logic [2:0]         s1_line_r;
  logic [7:0]         s1_data_r;
  logic               out_valid_r;
  logic [PIXEL_W-1:0] out_pixel_r;
  logic               out_pixel_valid_r;
  logic               out_not_empty_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               move, in_take;
  logic               push;
  logic [ROW_W-1:0]   row;
  logic [ADDR_W-1:0]  rd_addr_nxt;
  tpf_q_ctl_t         q_ctl;
  tpf_q_stat_t        q_stat;

  // item leaves the input register when the result register is free
  assign move     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || move;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_opcode_r <= in_opcode;
      s1_map_r    <= in_map_row_address;
      s1_line_r   <= in_tile_line;
      s1_data_r   <= in_read_data;
    end
  end

  tpf_fetch u_fetch (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (move),
    .opcode           (s1_opcode_r),
    .map_row_address  (s1_map_r),
    .tile_line        (s1_line_r),
    .read_data        (s1_data_r),
    .queue_level      (q_stat.level),
    .push             (push),
    .row              (row),
    .read_address_nxt (rd_addr_nxt)
  );

  assign q_ctl.clear = move && (s1_opcode_r == OP_START);
  assign q_ctl.pop   = move && (s1_opcode_r == OP_POP);
  assign q_ctl.push  = push;
  assign q_ctl.row   = row;

  tpf_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (q_ctl),
    .stat  (q_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_pixel_r       <= q_stat.pixel;
      out_pixel_valid_r <= q_stat.pixel_valid;
      out_not_empty_r   <= (q_stat.level_nxt != '0);
      out_addr_r        <= rd_addr_nxt;
      out_level_r       <= q_stat.level_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pixel           = out_pixel_r;
  assign out_pixel_valid     = out_pixel_valid_r;
  assign out_queue_not_empty = out_not_empty_r;
  assign out_read_address    = out_addr_r;
  assign out_queue_level     = out_level_r;

`ifndef SYNTHESIS
  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid_r)
    else $error("result register not loaded");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !move)
    else $error("pending result overwritten");
`endif

endmodule
